// ===== hw/rtl/two_voice_sample_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// Two-voice sample mixer assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_VOICE_SAMPLE_MIXER_MACROS_SVH
`define TWO_VOICE_SAMPLE_MIXER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TVSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvsm assertion failed");
// Next-cycle implication, checked outside reset.
`define TVSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvsm assertion failed");
`else
`define TVSM_ASSERT_IMP(label, ante, cons)
`define TVSM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/tvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-voice sample mixer package
// Command codes, field widths and mixing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tvsm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_BACK  = 2'd2;
  localparam logic [1:0] CMD_FORE  = 2'd3;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned ENTRY_W    = 33;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;

  localparam logic [7:0]  SILENCE    = 8'd128;
  localparam logic [7:0]  MAX_SAMPLE = 8'd255;
  // Exclusive end of the 16-bit address space.
  localparam logic [16:0] ADDR_SPAN  = 17'h10000;

endpackage

`default_nettype wire

// ===== hw/rtl/two_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// Two-voice sample mixer
// Plays 8-bit PCM from a sample store with a looping background voice and a
// one-shot, priority-arbitrated foreground voice.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ stream; in_tuser carries the command (tick, write
//   sample byte, play background, play foreground). Only a tick gives a
//   result item on the out_ stream: the mixed sample and both voice flags.
//   The sound table must be written over the cfg_ APB port while the block
//   idles; the block itself does not enforce this.
// Pacing: a write item completes on acceptance; a tick or a play request holds
//   off input while phase1_r is set, since the single-port sample store gives
//   one read per cycle and a tick reads the background and then the foreground
//   sample. Play requests use the phase1_r step for the registered table read.
// Reset: both voices go idle and the sound table reads as zero. The sample
//   store is not cleared; reading an unwritten byte gives an unknown value.
// Stall: the result waits in the output register while the next item is
//   accepted; a second tick holds its mix and stops input until the result
//   ahead is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_voice_sample_mixer_macros.svh"

module two_voice_sample_mixer #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned SOUND_COUNT = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sound_index[2:0], priority_req[10:3], write_address[26:11],
  // write_data[34:27], zero fill [39:35]
  input  wire logic [tvsm_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // sample[7:0], foreground_playing[8], background_playing[9], zero fill [15:10]
  output logic [tvsm_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [tvsm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [tvsm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tvsm_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned AW     = $clog2(STORE_DEPTH);
  localparam int unsigned SIDX_W = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;

  // Input field unpacking.
  logic [1:0]  in_cmd;
  logic [2:0]  in_sound_index;
  logic [7:0]  in_priority_req;
  logic [15:0] in_write_address;
  logic [7:0]  in_write_data;

  assign in_cmd           = in_tuser;
  assign in_sound_index   = in_tdata[2:0];
  assign in_priority_req  = in_tdata[10:3];
  assign in_write_address = in_tdata[26:11];
  assign in_write_data    = in_tdata[34:27];

  // Voice state.
  logic [15:0] back_pos_r, back_pos_nxt;
  logic [15:0] back_start_r, back_start_nxt;
  logic [16:0] back_end_r, back_end_nxt;
  logic        back_act_r, back_act_nxt;
  logic [15:0] fore_pos_r, fore_pos_nxt;
  logic [16:0] fore_end_r, fore_end_nxt;
  logic        fore_act_r, fore_act_nxt;
  logic [7:0]  fore_prio_r, fore_prio_nxt;

  // Item context for the phase1_r step.
  logic        phase1_r;
  logic [1:0]  cmd_r;
  logic [7:0]  prio_r;
  logic        idx_ok_r;

  // Mix stage.
  logic        mix_pend_r;
  logic        mix_fore_r;
  logic        mix_back_r;
  logic [7:0]  back_smp_r;
  logic        flag_fore_r;
  logic        flag_back_r;

  // Output register.
  logic                             out_vld_r;
  logic [tvsm_pkg::OUT_DATA_W-1:0]  out_data_r;

  logic out_blocked;
  logic mix_fire;
  logic in_acc;

  assign out_blocked = out_vld_r && !out_tready;
  assign mix_fire    = mix_pend_r && !out_blocked;
  assign in_tready   = rst_n && !phase1_r && !(mix_pend_r && out_blocked);
  assign in_acc      = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Sample store: single port, registered read data.
  // --------------------------------------------------------------------------
  logic [7:0] store_mem [STORE_DEPTH];
  logic [7:0] mem_q_r;
  logic       mem_oob_r;

  logic        st_we;
  logic        st_re;
  logic [15:0] st_addr;
  logic        st_in_range;

  always_comb begin
    st_we   = 1'b0;
    st_re   = 1'b0;
    st_addr = in_write_address;
    if (phase1_r && cmd_r == tvsm_pkg::CMD_TICK) begin
      st_re   = 1'b1;
      st_addr = fore_pos_r;
    end else if (in_acc && in_cmd == tvsm_pkg::CMD_TICK) begin
      st_re   = 1'b1;
      st_addr = back_pos_r;
    end else if (in_acc && in_cmd == tvsm_pkg::CMD_WRITE) begin
      st_we   = 1'b1;
      st_addr = in_write_address;
    end
  end

  assign st_in_range = ({1'b0, st_addr} < 17'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (st_we && st_in_range) begin
      store_mem[st_addr[AW-1:0]] <= in_write_data;
    end
    if (st_re) begin
      mem_q_r   <= store_mem[st_addr[AW-1:0]];
      mem_oob_r <= !st_in_range;
    end
  end

  logic [7:0] mem_smp;
  assign mem_smp = mem_oob_r ? 8'd0 : mem_q_r;

  // --------------------------------------------------------------------------
  // Sound table: one write port, two registered read ports. Entries without
  // a valid bit read as zero.
  // --------------------------------------------------------------------------
  logic [tvsm_pkg::ENTRY_W-1:0] tbl_mem [SOUND_COUNT];
  logic [SOUND_COUNT-1:0]       tbl_vld_r;
  logic [tvsm_pkg::ENTRY_W-1:0] tbl_q_r;
  logic [tvsm_pkg::CFG_DATA_W-1:0] prdata_r;

  logic [2:0] cfg_idx;
  logic       cfg_idx_ok;
  logic       cfg_wr;
  logic       play_idx_ok;

  assign cfg_idx     = cfg_paddr[5:3];
  assign cfg_idx_ok  = (32'(cfg_idx) < SOUND_COUNT);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_idx_ok;
  assign play_idx_ok = (32'(in_sound_index) < SOUND_COUNT);

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      tbl_mem[cfg_idx[SIDX_W-1:0]] <= cfg_pwdata[tvsm_pkg::ENTRY_W-1:0];
    end
    if (in_acc) begin
      if (play_idx_ok && tbl_vld_r[in_sound_index[SIDX_W-1:0]]) begin
        tbl_q_r <= tbl_mem[in_sound_index[SIDX_W-1:0]];
      end else begin
        tbl_q_r <= '0;
      end
    end
    // Read data is captured in the setup phase and shown in the access phase.
    if (cfg_psel && !cfg_penable) begin
      if (cfg_idx_ok && tbl_vld_r[cfg_idx[SIDX_W-1:0]]) begin
        prdata_r <= {{(tvsm_pkg::CFG_DATA_W - tvsm_pkg::ENTRY_W){1'b0}},
                     tbl_mem[cfg_idx[SIDX_W-1:0]]};
      end else begin
        prdata_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (cfg_wr) begin
      tbl_vld_r[cfg_idx[SIDX_W-1:0]] <= 1'b1;
    end
  end

  assign cfg_prdata = prdata_r;
  assign cfg_pready = 1'b1;

  // --------------------------------------------------------------------------
  // phase1_r step: sound decode and voice state update.
  // --------------------------------------------------------------------------
  logic [15:0] snd_start;
  logic [16:0] snd_end_raw;
  logic [16:0] snd_end;
  logic        snd_ok;
  logic [16:0] fore_inc;
  logic [16:0] back_inc;

  assign snd_start   = tbl_q_r[15:0];
  assign snd_end_raw = tbl_q_r[32:16];
  assign snd_end     = (snd_end_raw > tvsm_pkg::ADDR_SPAN) ? tvsm_pkg::ADDR_SPAN : snd_end_raw;
  assign snd_ok      = idx_ok_r && (snd_end > {1'b0, snd_start});
  assign fore_inc    = {1'b0, fore_pos_r} + 17'd1;
  assign back_inc    = {1'b0, back_pos_r} + 17'd1;

  always_comb begin
    back_pos_nxt   = back_pos_r;
    back_start_nxt = back_start_r;
    back_end_nxt   = back_end_r;
    back_act_nxt   = back_act_r;
    fore_pos_nxt   = fore_pos_r;
    fore_end_nxt   = fore_end_r;
    fore_act_nxt   = fore_act_r;
    fore_prio_nxt  = fore_prio_r;
    if (phase1_r) begin
      case (cmd_r)
        tvsm_pkg::CMD_TICK: begin
          if (back_act_r) begin
            if (fore_act_r) begin
              if (fore_inc >= fore_end_r) begin
                fore_act_nxt = 1'b0;
                fore_pos_nxt = 16'd0;
              end else begin
                fore_pos_nxt = fore_inc[15:0];
              end
            end
            if (back_inc >= back_end_r) begin
              back_pos_nxt = back_start_r;
            end else begin
              back_pos_nxt = back_inc[15:0];
            end
          end
        end
        tvsm_pkg::CMD_BACK: begin
          if (snd_ok) begin
            back_pos_nxt   = snd_start;
            back_start_nxt = snd_start;
            back_end_nxt   = snd_end;
            back_act_nxt   = 1'b1;
          end
        end
        tvsm_pkg::CMD_FORE: begin
          // A playing foreground keeps its place unless outranked.
          if (!(fore_act_r && fore_prio_r >= prio_r) && snd_ok) begin
            fore_pos_nxt  = snd_start;
            fore_end_nxt  = snd_end;
            fore_prio_nxt = prio_r;
            fore_act_nxt  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_pos_r   <= '0;
      back_start_r <= '0;
      back_end_r   <= '0;
      back_act_r   <= 1'b0;
      fore_pos_r   <= '0;
      fore_end_r   <= '0;
      fore_act_r   <= 1'b0;
      fore_prio_r  <= '0;
    end else begin
      back_pos_r   <= back_pos_nxt;
      back_start_r <= back_start_nxt;
      back_end_r   <= back_end_nxt;
      back_act_r   <= back_act_nxt;
      fore_pos_r   <= fore_pos_nxt;
      fore_end_r   <= fore_end_nxt;
      fore_act_r   <= fore_act_nxt;
      fore_prio_r  <= fore_prio_nxt;
    end
  end

  // Writes finish in their accept cycle; the other commands go on to a phase1_r step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase1_r <= 1'b0;
    end else begin
      phase1_r <= in_acc && (in_cmd != tvsm_pkg::CMD_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      prio_r   <= in_priority_req;
      idx_ok_r <= play_idx_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Mix stage: background sample is saved, foreground sample arrives from
  // the store in the next cycle.
  // --------------------------------------------------------------------------
  logic        tick_p1;
  assign tick_p1 = phase1_r && cmd_r == tvsm_pkg::CMD_TICK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_pend_r <= 1'b0;
    end else if (tick_p1) begin
      mix_pend_r <= 1'b1;
    end else if (mix_fire) begin
      mix_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_p1) begin
      back_smp_r  <= mem_smp;
      mix_back_r  <= back_act_r;
      mix_fore_r  <= back_act_r && fore_act_r;
      flag_fore_r <= fore_act_nxt;
      flag_back_r <= back_act_nxt;
    end
  end

  logic [8:0] mix_sum;
  logic [8:0] mix_diff;
  logic [7:0] mix_smp;

  assign mix_sum  = {1'b0, mem_smp} + {1'b0, back_smp_r};
  assign mix_diff = mix_sum - {1'b0, tvsm_pkg::SILENCE};

  always_comb begin
    if (!mix_back_r) begin
      mix_smp = tvsm_pkg::SILENCE;
    end else if (!mix_fore_r) begin
      mix_smp = back_smp_r;
    end else if (mix_sum < {1'b0, tvsm_pkg::SILENCE}) begin
      mix_smp = 8'd0;
    end else if (mix_diff > {1'b0, tvsm_pkg::MAX_SAMPLE}) begin
      mix_smp = tvsm_pkg::MAX_SAMPLE;
    end else begin
      mix_smp = mix_diff[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (mix_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_fire) begin
      out_data_r <= {6'd0, flag_back_r, flag_fore_r, mix_smp};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The foreground read of a phase1_r step must not clobber a held mix.
  `TVSM_ASSERT_IMP(a_phase1_no_mix, phase1_r, !mix_pend_r)
  // A stalled mix keeps waiting for the output register.
  `TVSM_ASSERT_NXT(a_mix_holds, mix_pend_r && out_blocked, mix_pend_r)
  // An accepted tick always reaches its phase1_r step.
  `TVSM_ASSERT_NXT(a_tick_p1, in_acc && in_cmd == tvsm_pkg::CMD_TICK,
                   phase1_r && cmd_r == tvsm_pkg::CMD_TICK)
  // A finished mix shows up as a result item.
  `TVSM_ASSERT_NXT(a_mix_out, mix_fire, out_vld_r && !mix_pend_r)

endmodule

`default_nettype wire
